FILE: rtl/qs_pkg.sv
// Shared types, widths and constants for the quaternion slerp pipeline.
// Depends on nothing; every rtl file imports it.
package qs_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int CORDIC_LEN   = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;

   localparam int CW     = 34;   // CORDIC x/y width, Q30 signed with headroom
   localparam int ZW     = 33;   // CORDIC angle width, Q30 signed
   localparam int SQW    = 58;   // integer square root working width
   localparam int SQ_N   = 29;   // one root bit per cell
   localparam int NW     = 46;   // divider numerator width
   localparam int QW     = 15;   // divider quotient bits
   localparam int CSR_AW = 3;

   localparam logic [14:0] ONE_Q14    = 15'd16384;
   localparam logic [28:0] ONE_Q28    = 29'h1000_0000;
   localparam logic [CW-1:0] GAIN_Q30 = CW'(652032874);
   localparam logic [14:0] THR_RESET  = 15'd16;
   localparam logic        REG_THRESHOLD = 1'b0;   // paddr[2] of the threshold

   typedef enum logic {
      CORDIC_ROTATE,
      CORDIC_VECTOR
   } cordic_mode_type;

   typedef struct packed {
      logic [3:0][16:0] a;      // first quaternion, sign fixed
      logic [3:0][15:0] b;
      logic [14:0]      t;
      logic [14:0]      thr;
      logic [33:0]      dots;   // signed dot product, Q28
      logic [28:0]      dot;    // |dot| clamped to one
      logic [28:0]      s28;    // sin(theta), Q28
      logic             slerp;
      logic [1:0]       neg;    // sine not positive, weight zero
      logic [1:0]       ovf;    // quotient at or above 2^15
      logic [14:0]      w0;
      logic [14:0]      w1;
   } ctx_type;

   function automatic logic [31:0] atan_q30(input logic [4:0] idx);
      logic [31:0] r;
      unique case (idx)
         5'd0:  r = 32'h3243F6A8;
         5'd1:  r = 32'h1DAC6705;
         5'd2:  r = 32'h0FADBAFC;
         5'd3:  r = 32'h07F56EA6;
         5'd4:  r = 32'h03FEAB76;
         5'd5:  r = 32'h01FFD55B;
         5'd6:  r = 32'h00FFFAAA;
         5'd7:  r = 32'h007FFF55;
         5'd8:  r = 32'h003FFFEA;
         5'd9:  r = 32'h001FFFFD;
         5'd10: r = 32'h000FFFFF;
         5'd11: r = 32'h0007FFFF;
         5'd12: r = 32'h0003FFFF;
         5'd13: r = 32'h0001FFFF;
         5'd14: r = 32'h0000FFFF;
         5'd15: r = 32'h00007FFF;
         5'd16: r = 32'h00003FFF;
         5'd17: r = 32'h00001FFF;
         5'd18: r = 32'h00000FFF;
         5'd19: r = 32'h000007FF;
         5'd20: r = 32'h000003FF;
         5'd21: r = 32'h000001FF;
         5'd22: r = 32'h000000FF;
         5'd23: r = 32'h0000007F;
         default: r = 32'h0;
      endcase
      return r;
   endfunction

endpackage

FILE: rtl/qs_sqrt_cell.sv
// One digit cell of the pipelined integer square root (one root bit per cell).
// Depends on qs_pkg.
module qs_sqrt_cell
   import qs_pkg::*;
(
   input  logic           clock,
   input  logic           en,
   input  logic [4:0]     k,       // this cell handles bit 4^k
   input  logic [SQW-1:0] v_in,
   input  logic [SQW-1:0] res_in,
   output logic [SQW-1:0] v_out,
   output logic [SQW-1:0] res_out
);

   logic [SQW-1:0] bit_w;
   logic [SQW-1:0] trial;
   logic [SQW-1:0] v_ff, v_in_n;
   logic [SQW-1:0] res_ff, res_in_n;

   always_comb begin
      bit_w = SQW'(1) << {k, 1'b0};
      trial = res_in + bit_w;
      if (v_in >= trial) begin
         v_in_n   = v_in - trial;
         res_in_n = (res_in >> 1) + bit_w;
      end else begin
         v_in_n   = v_in;
         res_in_n = res_in >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v_ff   <= v_in_n;
         res_ff <= res_in_n;
      end
   end

   assign v_out   = v_ff;
   assign res_out = res_ff;

endmodule

FILE: rtl/qs_cordic_cell.sv
// One CORDIC micro-rotation stage, vectoring or rotation mode.
// Depends on qs_pkg (atan table, widths).
module qs_cordic_cell
   import qs_pkg::*;
(
   input  logic                 clock,
   input  logic                 en,
   input  cordic_mode_type      mode,
   input  logic [4:0]           idx,
   input  logic signed [CW-1:0] x_in,
   input  logic signed [CW-1:0] y_in,
   input  logic signed [ZW-1:0] z_in,
   output logic signed [CW-1:0] x_out,
   output logic signed [CW-1:0] y_out,
   output logic signed [ZW-1:0] z_out
);

   logic signed [CW-1:0] dx, dy;
   logic signed [ZW-1:0] ang;
   logic                 go_sub, go_add;
   logic signed [CW-1:0] x_ff, x_in_n, y_ff, y_in_n;
   logic signed [ZW-1:0] z_ff, z_in_n;

   always_comb begin
      dx  = y_in >>> idx;
      dy  = x_in >>> idx;
      ang = $signed(ZW'(atan_q30(idx)));
      unique case (mode)
         CORDIC_VECTOR: begin
            go_sub = y_in < 0;
            go_add = y_in > 0;
         end
         CORDIC_ROTATE: begin
            go_sub = z_in >= 0;
            go_add = z_in < 0;
         end
         default: begin
            go_sub = 1'b0;
            go_add = 1'b0;
         end
      endcase
      x_in_n = x_in;
      y_in_n = y_in;
      z_in_n = z_in;
      if (go_sub) begin
         x_in_n = x_in - dx;
         y_in_n = y_in + dy;
         z_in_n = z_in - ang;
      end else if (go_add) begin
         x_in_n = x_in + dx;
         y_in_n = y_in - dy;
         z_in_n = z_in + ang;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_in_n;
         y_ff <= y_in_n;
         z_ff <= z_in_n;
      end
   end

   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;

endmodule

FILE: rtl/qs_div_cell.sv
// One restoring-division cell: tries divisor << k, sets quotient bit k.
// Depends on qs_pkg.
module qs_div_cell
   import qs_pkg::*;
(
   input  logic          clock,
   input  logic          en,
   input  logic [3:0]    k,
   input  logic [28:0]   d,
   input  logic [NW-1:0] rem_in,
   input  logic [QW-1:0] q_in,
   output logic [NW-1:0] rem_out,
   output logic [QW-1:0] q_out
);

   logic [NW-1:0] dsh;
   logic [NW-1:0] rem_ff, rem_in_n;
   logic [QW-1:0] q_ff, q_in_n;

   always_comb begin
      dsh = NW'(d) << k;
      if (rem_in >= dsh) begin
         rem_in_n = rem_in - dsh;
         q_in_n   = q_in | (QW'(1) << k);
      end else begin
         rem_in_n = rem_in;
         q_in_n   = q_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in_n;
         q_ff   <= q_in_n;
      end
   end

   assign rem_out = rem_ff;
   assign q_out   = q_ff;

endmodule

FILE: rtl/quaternion_slerp_top.sv
// Quaternion slerp, fully pipelined as rows of sqrt, CORDIC and divider cells.
// Depends on qs_pkg, qs_sqrt_cell, qs_cordic_cell, qs_div_cell.
//
//   channel  dir  width  content
//   req_*    in   144    a_x a_y a_z a_w b_x b_y b_z b_w blend
//   rsp_*    out  64     out_x out_y out_z out_w
//   csr_*    io   32     near_parallel_threshold at address 0
//
// One item per cycle while the output is not stalled; with 16 CORDIC steps the
// stages are 5 dot/radicand prep + 29 root cells + 16 vectoring + 1 phase + 16 rotation
// + 1 divider setup + 15 divider cells + 3 weight select/blend/output.
// The whole pipeline advances together; it stalls only while the output
// register holds a result that has not been taken.
// Synchronous reset clears the valid bits and the threshold (to 16).
module quaternion_slerp_top
   import qs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [143:0]      req_tdata,   // a_x,a_y,a_z,a_w,b_x,b_y,b_z,b_w,blend,pad
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [63:0]       rsp_tdata,   // out_x,out_y,out_z,out_w
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   localparam int ST_IN     = 0;
   localparam int ST_DOT    = 1;
   localparam int ST_FIX    = 2;
   localparam int ST_SQ     = 3;
   localparam int ST_REM    = 4;
   localparam int SQ_LAST   = ST_REM + SQ_N;
   localparam int VEC_LAST  = SQ_LAST + CORDIC_LEN;
   localparam int ST_MUL    = VEC_LAST + 1;
   localparam int ROT_LAST  = ST_MUL + CORDIC_LEN;
   localparam int ST_DPRE   = ROT_LAST + 1;
   localparam int DIV_LAST  = ST_DPRE + QW;
   localparam int ST_WSEL   = DIV_LAST + 1;
   localparam int ST_BMUL   = ST_WSEL + 1;
   localparam int ST_OUT    = ST_BMUL + 1;
   localparam int NST       = ST_OUT + 1;
   localparam int CTX_N     = ST_WSEL + 1;

   // ---------------- configuration ----------------
   logic [14:0] thr_ff;

   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && csr_paddr[2] == REG_THRESHOLD) begin
         thr_ff <= csr_pwdata[14:0];
      end
   end
   assign csr_prdata = (csr_paddr[2] == REG_THRESHOLD) ? {17'd0, thr_ff} : 32'd0;

   // ---------------- pipeline control ----------------
   logic           en;
   logic [NST-1:0] vld_ff;

   assign en         = !vld_ff[ST_OUT] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[ST_OUT];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NST-2:0], req_tvalid};
      end
   end

   // ---------------- side context ----------------
   ctx_type ctx_ff [CTX_N];
   ctx_type ctx_in [CTX_N];

   logic signed [31:0]  prod_ff [4];
   logic [57:0]         dsq_ff;
   logic [56:0]         rem_ff;

   logic [SQW-1:0]      sq_v [SQ_N];
   logic [SQW-1:0]      sq_r [SQ_N];
   logic signed [CW-1:0] vx [CORDIC_LEN];
   logic signed [CW-1:0] vy [CORDIC_LEN];
   logic signed [ZW-1:0] vz [CORDIC_LEN];
   logic signed [ZW-1:0] ph_ff [2];
   logic signed [CW-1:0] rx [2][CORDIC_LEN];
   logic signed [CW-1:0] ry [2][CORDIC_LEN];
   logic signed [ZW-1:0] rz [2][CORDIC_LEN];
   logic [NW-1:0]       n_ff [2];
   logic [NW-1:0]       dr [2][QW];
   logic [QW-1:0]       dq [2][QW];
   logic signed [32:0]  pa_ff [4];
   logic signed [31:0]  pb_ff [4];
   logic [15:0]         out_ff [4];

   logic signed [33:0]  dsum;
   logic [33:0]         dabs;
   logic [28:0]         dclamp;
   logic [28:0]         s28_w;
   logic signed [CW-1:0] sn [2];
   logic [NW-1:0]       nn [2];
   logic [1:0]          neg_n, ovf_n;
   logic [14:0]         wt [2];
   logic [14:0]         tsat;

   always_comb begin
      tsat = (req_tdata[142:128] > ONE_Q14) ? ONE_Q14 : req_tdata[142:128];
      ctx_in[0]       = '0;
      for (int i = 0; i < 4; i++) begin
         ctx_in[0].a[i] = {req_tdata[16*i+15], req_tdata[16*i +: 16]};
         ctx_in[0].b[i] = req_tdata[64+16*i +: 16];
      end
      ctx_in[0].t   = tsat;
      ctx_in[0].thr = thr_ff;
      for (int j = 1; j < CTX_N; j++) begin
         ctx_in[j] = ctx_ff[j-1];
      end

      // dot product and sign fix
      dsum = 34'(prod_ff[0]) + 34'(prod_ff[1]) + 34'(prod_ff[2]) + 34'(prod_ff[3]);
      ctx_in[ST_DOT].dots = dsum;
      dabs   = ctx_ff[ST_DOT].dots[33] ? (34'd0 - ctx_ff[ST_DOT].dots)
                                       : ctx_ff[ST_DOT].dots;
      dclamp = (dabs > 34'(ONE_Q28)) ? ONE_Q28 : dabs[28:0];
      if (ctx_ff[ST_DOT].dots[33]) begin
         for (int i = 0; i < 4; i++) begin
            ctx_in[ST_FIX].a[i] = 17'd0 - ctx_ff[ST_DOT].a[i];
         end
      end
      ctx_in[ST_FIX].dot   = dclamp;
      ctx_in[ST_FIX].w0    = ONE_Q14 - ctx_ff[ST_DOT].t;
      ctx_in[ST_FIX].w1    = ctx_ff[ST_DOT].t;
      ctx_in[ST_FIX].slerp = (ONE_Q28 - dclamp) > {ctx_ff[ST_DOT].thr, 14'd0};

      // root result joins the context
      s28_w = sq_r[SQ_N-1][28:0];
      ctx_in[SQ_LAST+1].s28   = s28_w;
      ctx_in[SQ_LAST+1].slerp = ctx_ff[SQ_LAST].slerp && (s28_w != 29'd0);

      // divider setup: numerator sin*4096, early overflow test
      for (int j = 0; j < 2; j++) begin
         sn[j]    = ry[j][CORDIC_LEN-1];
         nn[j]    = {sn[j], 12'd0};
         neg_n[j] = sn[j][CW-1] || (sn[j] == '0);
         ovf_n[j] = nn[j] >= {2'd0, ctx_ff[ROT_LAST].s28, 15'd0};
      end
      ctx_in[ST_DPRE].neg = neg_n;
      ctx_in[ST_DPRE].ovf = ovf_n;

      // final weights
      for (int j = 0; j < 2; j++) begin
         if (ctx_ff[DIV_LAST].neg[j]) begin
            wt[j] = 15'd0;
         end else if (ctx_ff[DIV_LAST].ovf[j] || dq[j][QW-1] > ONE_Q14) begin
            wt[j] = ONE_Q14;
         end else begin
            wt[j] = dq[j][QW-1];
         end
      end
      if (ctx_ff[DIV_LAST].slerp) begin
         ctx_in[ST_WSEL].w0 = wt[0];
         ctx_in[ST_WSEL].w1 = wt[1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < CTX_N; j++) begin
            ctx_ff[j] <= ctx_in[j];
         end
      end
   end

   // ---------------- dot products and radicand ----------------
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++) begin
            prod_ff[i] <= $signed(req_tdata[16*i +: 16]) * $signed(req_tdata[64+16*i +: 16]);
         end
         dsq_ff <= 58'(ctx_ff[ST_FIX].dot) * 58'(ctx_ff[ST_FIX].dot);
         rem_ff <= {1'b1, 56'd0} - dsq_ff[56:0];
      end
   end

   // ---------------- square root row ----------------
   for (genvar c = 0; c < SQ_N; c++) begin : g_sqrt
      if (c == 0) begin : g_first
         qs_sqrt_cell u_cell (
            .clock (clock), .en (en), .k (5'(SQ_N - 1 - c)),
            .v_in (SQW'(rem_ff)), .res_in ('0),
            .v_out (sq_v[c]), .res_out (sq_r[c])
         );
      end else begin : g_next
         qs_sqrt_cell u_cell (
            .clock (clock), .en (en), .k (5'(SQ_N - 1 - c)),
            .v_in (sq_v[c-1]), .res_in (sq_r[c-1]),
            .v_out (sq_v[c]), .res_out (sq_r[c])
         );
      end
   end

   // ---------------- CORDIC vectoring row: theta = acos(dot) ----------------
   for (genvar c = 0; c < CORDIC_LEN; c++) begin : g_vec
      if (c == 0) begin : g_first
         qs_cordic_cell u_cell (
            .clock (clock), .en (en), .mode (CORDIC_VECTOR), .idx (5'(c)),
            .x_in ($signed({3'd0, ctx_ff[SQ_LAST].dot, 2'd0})),
            .y_in ($signed({3'd0, s28_w, 2'd0})),
            .z_in ('0),
            .x_out (vx[c]), .y_out (vy[c]), .z_out (vz[c])
         );
      end else begin : g_next
         qs_cordic_cell u_cell (
            .clock (clock), .en (en), .mode (CORDIC_VECTOR), .idx (5'(c)),
            .x_in (vx[c-1]), .y_in (vy[c-1]), .z_in (vz[c-1]),
            .x_out (vx[c]), .y_out (vy[c]), .z_out (vz[c])
         );
      end
   end

   // ---------------- phases ----------------
   logic signed [ZW+15:0] phm [2];
   always_comb begin
      phm[0] = vz[CORDIC_LEN-1] * $signed({1'b0, ctx_ff[VEC_LAST].w0});
      phm[1] = vz[CORDIC_LEN-1] * $signed({1'b0, ctx_ff[VEC_LAST].w1});
   end
   always_ff @(posedge clock) begin
      if (en) begin
         ph_ff[0] <= phm[0][ZW+13:14];
         ph_ff[1] <= phm[1][ZW+13:14];
      end
   end

   // ---------------- CORDIC rotation rows, divider rows ----------------
   for (genvar j = 0; j < 2; j++) begin : g_wt
      for (genvar c = 0; c < CORDIC_LEN; c++) begin : g_rot
         if (c == 0) begin : g_first
            qs_cordic_cell u_cell (
               .clock (clock), .en (en), .mode (CORDIC_ROTATE), .idx (5'(c)),
               .x_in ($signed(GAIN_Q30)), .y_in ('0), .z_in (ph_ff[j]),
               .x_out (rx[j][c]), .y_out (ry[j][c]), .z_out (rz[j][c])
            );
         end else begin : g_next
            qs_cordic_cell u_cell (
               .clock (clock), .en (en), .mode (CORDIC_ROTATE), .idx (5'(c)),
               .x_in (rx[j][c-1]), .y_in (ry[j][c-1]), .z_in (rz[j][c-1]),
               .x_out (rx[j][c]), .y_out (ry[j][c]), .z_out (rz[j][c])
            );
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            n_ff[j] <= nn[j];
         end
      end

      for (genvar c = 0; c < QW; c++) begin : g_div
         if (c == 0) begin : g_first
            qs_div_cell u_cell (
               .clock (clock), .en (en), .k (4'(QW - 1 - c)),
               .d (ctx_ff[ST_DPRE].s28),
               .rem_in (n_ff[j]), .q_in ('0),
               .rem_out (dr[j][c]), .q_out (dq[j][c])
            );
         end else begin : g_next
            qs_div_cell u_cell (
               .clock (clock), .en (en), .k (4'(QW - 1 - c)),
               .d (ctx_ff[ST_DPRE + c].s28),
               .rem_in (dr[j][c-1]), .q_in (dq[j][c-1]),
               .rem_out (dr[j][c]), .q_out (dq[j][c])
            );
         end
      end
   end

   // ---------------- blend and saturate ----------------
   logic signed [34:0] acc [4];
   logic signed [20:0] sh [4];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++) begin
            pa_ff[i] <= $signed(ctx_ff[ST_WSEL].a[i]) * $signed({1'b0, ctx_ff[ST_WSEL].w0});
            pb_ff[i] <= $signed(ctx_ff[ST_WSEL].b[i]) * $signed({1'b0, ctx_ff[ST_WSEL].w1});
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         acc[i] = 35'(pa_ff[i]) + 35'(pb_ff[i]) + 35'sd8192;
         sh[i]  = acc[i][34:14];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++) begin
            if (sh[i] > 21'sd32767) begin
               out_ff[i] <= 16'h7FFF;
            end else if (sh[i] < -21'sd32768) begin
               out_ff[i] <= 16'h8000;
            end else begin
               out_ff[i] <= sh[i][15:0];
            end
         end
      end
   end

   assign rsp_tdata = {out_ff[3], out_ff[2], out_ff[1], out_ff[0]};

`ifndef SYNTH
   a_stall_blocks_input : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while output stalled");

   a_dot_clamped : assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_FIX] |-> ctx_ff[ST_FIX].dot <= ONE_Q28)
      else $error("dot above one after clamp");

   a_weight_range : assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_WSEL] |-> ctx_ff[ST_WSEL].w0 <= ONE_Q14 && ctx_ff[ST_WSEL].w1 <= ONE_Q14)
      else $error("weight above one");

   a_linear_sum : assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_WSEL] && !ctx_ff[ST_WSEL].slerp
      |-> 16'(ctx_ff[ST_WSEL].w0) + 16'(ctx_ff[ST_WSEL].w1) == 16'(ONE_Q14))
      else $error("linear weights do not sum to one");
`endif

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for quaternion_slerp_top: streams quaternion pairs,
// predicts each blended quaternion in fixed point and checks every transfer.
// Depends on qs_pkg and the rtl under rtl/.
`timescale 1ns / 100ps

module tb_top;
   import qs_pkg::*;

   localparam longint ONE28     = 64'sd268435456;
   localparam longint GAIN30    = 64'sd652032874;
   localparam int     IDLE_MAX  = 20000;
   localparam int     DRAIN_CYC = 120;
   localparam longint ATAN_TAB [24] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
      64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
      64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
      64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [143:0]      req_tdata;   // a_x,a_y,a_z,a_w,b_x,b_y,b_z,b_w,blend,pad
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [63:0]       rsp_tdata;   // out_x,out_y,out_z,out_w
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [31:0]       csr_pwdata;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   logic [14:0] threshold;
   logic [63:0] blend_queue [$];
   int          error_count;
   int          idle_cycles;
   int          stall_left;
   bit          rsp_stall_on;

   quaternion_slerp_top u_dut (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------- fixed-point slerp predictor ----------------
   function automatic longint unsigned root56(longint unsigned v);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic longint vector_angle(longint x, longint y);
      longint z, dx, dy;
      z = 0;
      for (int i = 0; i < CORDIC_LEN; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x += dx; y -= dy; z += ATAN_TAB[i];
         end else if (y < 0) begin
            x -= dx; y += dy; z -= ATAN_TAB[i];
         end
      end
      return z;
   endfunction

   function automatic longint rotate_sine(longint z);
      longint x, y, dx, dy;
      x = GAIN30;
      y = 0;
      for (int i = 0; i < CORDIC_LEN; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= ATAN_TAB[i];
         end else begin
            x += dx; y -= dy; z += ATAN_TAB[i];
         end
      end
      return y;
   endfunction

   function automatic longint arc_weight(longint theta, longint w, longint sin_theta);
      longint s, r;
      s = rotate_sine((theta * w) >>> 14);
      r = (s * 4096) / sin_theta;
      if (r < 0) r = 0;
      if (r > 16384) r = 16384;
      return r;
   endfunction

   function automatic logic [63:0] predict_blend(logic [143:0] d, logic [14:0] thr);
      longint a [4], b [4];
      longint dot, t, w0, w1, s28, theta, n0, n1, v;
      logic [63:0] r;
      dot = 0;
      for (int i = 0; i < 4; i++) begin
         a[i] = longint'($signed(d[16*i +: 16]));
         b[i] = longint'($signed(d[64 + 16*i +: 16]));
         dot += a[i] * b[i];
      end
      t = longint'(d[142:128]);
      if (t > 16384) t = 16384;
      // take the shorter arc
      if (dot < 0) begin
         for (int i = 0; i < 4; i++) a[i] = -a[i];
         dot = -dot;
      end
      if (dot > ONE28) dot = ONE28;
      w0 = 16384 - t;
      w1 = t;
      if ((ONE28 - dot) > longint'(thr) * 16384) begin
         s28 = longint'(root56((64'd1 << 56) - longint'(dot * dot)));
         if (s28 != 0) begin
            theta = vector_angle(dot * 4, s28 * 4);
            n0 = arc_weight(theta, w0, s28);
            n1 = arc_weight(theta, w1, s28);
            w0 = n0;
            w1 = n1;
         end
      end
      for (int i = 0; i < 4; i++) begin
         v = (a[i] * w0 + b[i] * w1 + 8192) >>> 14;
         if (v > 32767) v = 32767;
         if (v < -32768) v = -32768;
         r[16*i +: 16] = v[15:0];
      end
      return r;
   endfunction

   // ---------------- stimulus helpers ----------------
   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 45) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   task automatic send_pair(logic [63:0] qa, logic [63:0] qb, logic [14:0] t, bit gaps);
      int gap;
      gap = gaps ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {1'b0, t, qb, qa};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      blend_queue.push_back(predict_blend({1'b0, t, qb, qa}, threshold));
   endtask

   task automatic write_threshold(logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= '0;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      threshold   = value[14:0];
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (blend_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
   endtask

   function automatic logic [63:0] pack_quat(real x, real y, real z, real w);
      return {16'($rtoi(w)), 16'($rtoi(z)), 16'($rtoi(y)), 16'($rtoi(x))};
   endfunction

   function automatic real rnd_comp(int span);
      return real'($urandom_range(0, 2 * span)) - real'(span);
   endfunction

   // unit-length pair, b a perturbed copy of a so both blend paths are hit
   task automatic send_unit_pair(bit gaps);
      real ax, ay, az, aw, bx, by, bz, bw, n, sc;
      int  span;
      do begin
         ax = rnd_comp(1000); ay = rnd_comp(1000); az = rnd_comp(1000); aw = rnd_comp(1000);
         n  = $sqrt(ax*ax + ay*ay + az*az + aw*aw);
      end while (n < 1.0);
      sc = 16383.0 / n;
      ax *= sc; ay *= sc; az *= sc; aw *= sc;
      span = ($urandom_range(0, 3) == 0) ? 16000 : $urandom_range(0, 600);
      do begin
         bx = ax + rnd_comp(span); by = ay + rnd_comp(span);
         bz = az + rnd_comp(span); bw = aw + rnd_comp(span);
         n  = $sqrt(bx*bx + by*by + bz*bz + bw*bw);
      end while (n < 1.0);
      sc = (($urandom_range(0, 1) == 1) ? 16383.0 : -16383.0) / n;
      send_pair(pack_quat(ax, ay, az, aw), pack_quat(bx*sc, by*sc, bz*sc, bw*sc),
                15'($urandom_range(0, 16384)), gaps);
   endtask

   task automatic send_mixed(bit gaps);
      int p;
      p = $urandom_range(0, 99);
      if (p < 70)
         send_unit_pair(gaps);
      else
         send_pair({$urandom, $urandom}, {$urandom, $urandom}, 15'($urandom), gaps);
   endtask

   // ---------------- tests ----------------
   task automatic test_directed();
      logic [63:0] ones, qmax, qmin, unit_w, unit_x, half;
      ones   = {4{16'sd16384}};
      qmax   = {4{16'h7FFF}};
      qmin   = {4{16'h8000}};
      unit_w = {16'sd16384, 48'd0};
      unit_x = {48'd0, 16'sd16384};
      half   = {16'sd11585, 32'd0, 16'sd11585};
      send_pair(qmax, qmax, 15'd0, 0);             // dot above one
      send_pair(qmin, qmin, 15'd16384, 0);
      send_pair(qmin, qmax, 15'd8192, 0);          // negative dot, negated -32768
      send_pair(qmax, qmin, 15'h7FFF, 0);          // blend above one
      send_pair(unit_w, unit_w, 15'd4096, 0);      // parallel
      send_pair(unit_w, -unit_w, 15'd4096, 0);     // antiparallel
      send_pair(unit_w, unit_x, 15'd0, 0);         // right angle
      send_pair(unit_w, unit_x, 15'd16384, 0);
      send_pair(unit_w, unit_x, 15'd8192, 0);
      send_pair(unit_w, half, 15'd5000, 0);
      send_pair(unit_x, {unit_w[63:48] ^ 16'h0001, 48'd0}, 15'd12000, 0);
      send_pair('0, '0, 15'd8192, 0);              // zero vectors
      send_pair('0, ones, 15'd16385, 0);
      send_pair({4{16'h5555}}, {4{16'hAAAA}}, 15'h5555, 0);
      send_pair({4{16'hAAAA}}, {4{16'h5555}}, 15'h2AAA, 0);
      for (int i = 0; i < 6; i++) send_unit_pair(0);
      wait_idle();
   endtask

   task automatic test_threshold_sweep();
      logic [31:0] settings [5];
      settings = '{32'd0, 32'd16384, 32'h7FFF, 32'hFFFF_8000 | 32'd300, 32'd16};
      foreach (settings[k]) begin
         write_threshold(settings[k]);
         for (int i = 0; i < 150; i++) send_mixed(1);
         wait_idle();
      end
   endtask

   task automatic test_random_blends();
      for (int k = 0; k < 3; k++) begin
         write_threshold($urandom_range(0, 400));
         for (int i = 0; i < 260; i++) send_mixed(k != 1);   // one burst phase
         wait_idle();
      end
   endtask

   // ---------------- result checking ----------------
   always @(posedge clock) begin
      logic [63:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (blend_queue.size() == 0) begin
            $error("result transfer with nothing expected: %h", rsp_tdata);
            error_count++;
         end else begin
            want = blend_queue.pop_front();
            if (want[15:0] !== rsp_tdata[15:0]) begin
               $error("out_x expected %0d actual %0d", $signed(want[15:0]),
                      $signed(rsp_tdata[15:0]));
               error_count++;
            end
            if (want[31:16] !== rsp_tdata[31:16]) begin
               $error("out_y expected %0d actual %0d", $signed(want[31:16]),
                      $signed(rsp_tdata[31:16]));
               error_count++;
            end
            if (want[47:32] !== rsp_tdata[47:32]) begin
               $error("out_z expected %0d actual %0d", $signed(want[47:32]),
                      $signed(rsp_tdata[47:32]));
               error_count++;
            end
            if (want[63:48] !== rsp_tdata[63:48]) begin
               $error("out_w expected %0d actual %0d", $signed(want[63:48]),
                      $signed(rsp_tdata[63:48]));
               error_count++;
            end
         end
      end
   end

   // receiver back-pressure: mostly short stalls, now and then a long run
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b1;
         stall_left <= 0;
      end else if (rsp_stall_on) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 99) < 2) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(4, 40);
      end else begin
         rsp_tready <= ($urandom_range(0, 99) < 70);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_MAX) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      rsp_tready   = 1'b1;
      rsp_stall_on = 1'b0;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      threshold    = 15'd16;
      error_count  = 0;
      idle_cycles  = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_threshold_sweep();
      rsp_stall_on = 1'b1;     // a stretch with the receiver always ready
      test_random_blends();
      rsp_stall_on = 1'b0;
      for (int i = 0; i < 100; i++) send_mixed(1);
      wait_idle();

      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
